// File: rtl/rgbmm_pkg.sv
// ----------------------------------------------------------------------------
// rgbmm_pkg
// Shared types and constants of the per-channel rgb matrix multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbmm_pkg;

  localparam int MAX_DIM_DEF = 16;
  localparam int DIM_RESET   = 16;
  localparam int DIM_W       = 5;
  localparam int IDX_W       = 4;
  localparam int CH_W        = 8;
  localparam int KIND_W      = 2;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;
  localparam int REG_IDX_W   = 2;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LEFT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RIGHT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_LEFT_ROWS  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_COLS = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
    logic [CH_W-1:0]   red_in;
    logic [CH_W-1:0]   green_in;
    logic [CH_W-1:0]   blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [DIM_W-1:0] left_rows;
    logic [DIM_W-1:0] inner_size;
    logic [DIM_W-1:0] right_cols;
  } dims_t;

  typedef struct packed {
    logic             we_left;
    logic             we_right;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    rgb_t             data;
  } store_wr_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [DIM_W-1:0] step;
  } store_rd_t;

  typedef struct packed {
    logic clear;
    logic acc;
    logic emit;
    logic oor;
  } mac_ctl_t;

endpackage

`default_nettype wire

// File: rtl/rgb_channel_matrix_multiply.sv
// ----------------------------------------------------------------------------
// rgb_channel_matrix_multiply
// Per-channel rgb matrix multiply with byte-wide results, queried by position.
// ----------------------------------------------------------------------------
//  channel  ports                                   handshake
//  input    start, busy, in_item                    taken when start and !busy
//  result   out_strobe, out_item                    one-cycle strobe, no stall
//  config   psel penable pwrite paddr pwdata        apb, pready always high
//           prdata pready
//
//  a load item leaves busy low.
//  an in-range query holds busy through the inner walk and its last state; the walk reads
//  one left/right element pair per cycle from the two stores' read ports.
//  an out-of-range query, or one with inner_size zero, leaves busy low.
//  the result strobe comes in the same cycle that busy drops (or in the cycle after acceptance).
//  reset is synchronous; dimensions reset to 16, the stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_channel_matrix_multiply #(
  parameter int MAX_DIM = rgbmm_pkg::MAX_DIM_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire rgbmm_pkg::in_item_t          in_item,
  output logic                              out_strobe,
  output rgbmm_pkg::out_item_t              out_item,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rgbmm_pkg::CFG_AW-1:0] paddr,
  input  wire logic [rgbmm_pkg::CFG_DW-1:0] pwdata,
  output logic      [rgbmm_pkg::CFG_DW-1:0] prdata,
  output logic                              pready
);

  localparam int DIM_W = rgbmm_pkg::DIM_W;
  localparam int IDX_W = rgbmm_pkg::IDX_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;

  rgbmm_pkg::dims_t     dims;
  rgbmm_pkg::store_wr_t wr;
  rgbmm_pkg::store_rd_t rd;
  rgbmm_pkg::mac_ctl_t  ctl;
  rgbmm_pkg::rgb_t      left_q, right_q;

  logic [1:0]       state_r, state_nxt;
  logic [DIM_W-1:0] step_r, step_nxt;
  logic [IDX_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic             rd_vld_r, rd_last_r;
  logic             accept, is_query, q_oor, q_empty, last_issue;
  logic [DIM_W-1:0] row_ext, col_ext;

  rgbmm_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims    (dims)
  );

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign is_query = accept && (in_item.kind == rgbmm_pkg::KIND_QUERY);
  assign row_ext  = DIM_W'(in_item.row_index);
  assign col_ext  = DIM_W'(in_item.col_index);
  assign q_oor    = (row_ext >= dims.left_rows) || (col_ext >= dims.right_cols);
  assign q_empty  = (dims.inner_size == '0);

  // loads land in the store at the accept edge, out-of-size loads dropped
  always_comb begin
    wr.we_left  = accept && (in_item.kind == rgbmm_pkg::KIND_LEFT)
                  && (row_ext < dims.left_rows) && (col_ext < dims.inner_size);
    wr.we_right = accept && (in_item.kind == rgbmm_pkg::KIND_RIGHT)
                  && (row_ext < dims.inner_size) && (col_ext < dims.right_cols);
    wr.row        = in_item.row_index;
    wr.col        = in_item.col_index;
    wr.data.red   = in_item.red_in;
    wr.data.green = in_item.green_in;
    wr.data.blue  = in_item.blue_in;
  end

  assign last_issue = (DIM_W'(step_r + 1'b1) == dims.inner_size);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    rd.re     = 1'b0;
    rd.row    = row_r;
    rd.col    = col_r;
    rd.step   = step_r;
    ctl.clear = is_query;
    ctl.acc   = rd_vld_r;
    ctl.emit  = is_query && (q_oor || q_empty);
    ctl.oor   = q_oor;
    case (state_r)
      ST_IDLE: begin
        if (is_query && !q_oor && !q_empty) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
          row_nxt   = in_item.row_index;
          col_nxt   = in_item.col_index;
        end
      end
      ST_RUN: begin
        rd.re    = 1'b1;
        step_nxt = DIM_W'(step_r + 1'b1);
        if (last_issue) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        // final pair is in the read registers now
        ctl.oor  = 1'b0;
        ctl.emit = rd_vld_r && rd_last_r;
        if (rd_last_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= rd.re;
      rd_last_r <= rd.re && last_issue;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
  end

  rgbmm_store #(.MAX_DIM(MAX_DIM)) u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .left_q  (left_q),
    .right_q (right_q)
  );

  rgbmm_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .left_q     (left_q),
    .right_q    (right_q),
    .out_item   (out_item),
    .out_strobe (out_strobe)
  );

  // a result only follows a query accepted or a walk in progress
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy || (start && in_item.kind == rgbmm_pkg::KIND_QUERY)))
    else $error("result strobe without a query");

  // out-of-range answers come straight from acceptance, never from a walk
  a_oor_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.out_of_range) |-> $past(start && !busy))
    else $error("out-of-range result after a walk");

  // the walk never reads past the inner dimension
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (step_r < dims.inner_size))
    else $error("inner step beyond inner_size");

  // a walk ends with the read of its last pair
  a_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LAST) |-> (rd_vld_r && rd_last_r))
    else $error("last state without final pair");

endmodule

`default_nettype wire

// File: rtl/rgbmm_cfg.sv
// ----------------------------------------------------------------------------
// rgbmm_cfg
// Dimension registers behind the apb port, clamped to MAX_DIM on write.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbmm_cfg #(
  parameter int MAX_DIM = rgbmm_pkg::MAX_DIM_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rgbmm_pkg::CFG_AW-1:0] paddr,
  input  wire logic [rgbmm_pkg::CFG_DW-1:0] pwdata,
  output logic      [rgbmm_pkg::CFG_DW-1:0] prdata,
  output logic                              pready,
  output rgbmm_pkg::dims_t                  dims
);

  localparam int DIM_W = rgbmm_pkg::DIM_W;
  localparam int RESET_VAL = (rgbmm_pkg::DIM_RESET > MAX_DIM) ? MAX_DIM
                                                              : rgbmm_pkg::DIM_RESET;

  rgbmm_pkg::dims_t dims_r, dims_nxt;
  logic [DIM_W-1:0] wval;
  logic [rgbmm_pkg::REG_IDX_W-1:0] reg_idx;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rgbmm_pkg::CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // values above the maximum act as the maximum
  always_comb begin
    if (32'(pwdata[DIM_W-1:0]) > 32'(MAX_DIM)) begin
      wval = DIM_W'(MAX_DIM);
    end else begin
      wval = pwdata[DIM_W-1:0];
    end
  end

  always_comb begin
    dims_nxt = dims_r;
    if (wr_en) begin
      case (reg_idx)
        rgbmm_pkg::REG_LEFT_ROWS:  dims_nxt.left_rows  = wval;
        rgbmm_pkg::REG_INNER_SIZE: dims_nxt.inner_size = wval;
        rgbmm_pkg::REG_RIGHT_COLS: dims_nxt.right_cols = wval;
        default: dims_nxt = dims_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.left_rows  <= DIM_W'(RESET_VAL);
      dims_r.inner_size <= DIM_W'(RESET_VAL);
      dims_r.right_cols <= DIM_W'(RESET_VAL);
    end else begin
      dims_r <= dims_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      rgbmm_pkg::REG_LEFT_ROWS:  prdata = rgbmm_pkg::CFG_DW'(dims_r.left_rows);
      rgbmm_pkg::REG_INNER_SIZE: prdata = rgbmm_pkg::CFG_DW'(dims_r.inner_size);
      rgbmm_pkg::REG_RIGHT_COLS: prdata = rgbmm_pkg::CFG_DW'(dims_r.right_cols);
      default:                   prdata = '0;
    endcase
  end

  assign dims = dims_r;

endmodule

`default_nettype wire

// File: rtl/rgbmm_store.sv
// ----------------------------------------------------------------------------
// rgbmm_store
// Left and right element memories, one write and one registered read each.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbmm_store #(
  parameter int MAX_DIM = rgbmm_pkg::MAX_DIM_DEF
) (
  input  wire logic                 clk,
  input  wire rgbmm_pkg::store_wr_t wr,
  input  wire rgbmm_pkg::store_rd_t rd,
  output rgbmm_pkg::rgb_t           left_q,
  output rgbmm_pkg::rgb_t           right_q
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  rgbmm_pkg::rgb_t left_mem  [DEPTH];
  rgbmm_pkg::rgb_t right_mem [DEPTH];
  rgbmm_pkg::rgb_t left_q_r, right_q_r;

  logic [AW-1:0] wr_addr, left_raddr, right_raddr;

  // row-major entries, MAX_DIM to a row
  assign wr_addr     = AW'(int'(wr.row) * MAX_DIM + int'(wr.col));
  assign left_raddr  = AW'(int'(rd.row) * MAX_DIM + int'(rd.step));
  assign right_raddr = AW'(int'(rd.step) * MAX_DIM + int'(rd.col));

  always_ff @(posedge clk) begin
    if (wr.we_left) begin
      left_mem[wr_addr] <= wr.data;
    end
    if (wr.we_right) begin
      right_mem[wr_addr] <= wr.data;
    end
    if (rd.re) begin
      left_q_r  <= left_mem[left_raddr];
      right_q_r <= right_mem[right_raddr];
    end
  end

  assign left_q  = left_q_r;
  assign right_q = right_q_r;

endmodule

`default_nettype wire

// File: rtl/rgbmm_mac.sv
// ----------------------------------------------------------------------------
// rgbmm_mac
// Three byte-wide multiply-accumulate channels and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbmm_mac (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rgbmm_pkg::mac_ctl_t ctl,
  input  wire rgbmm_pkg::rgb_t     left_q,
  input  wire rgbmm_pkg::rgb_t     right_q,
  output rgbmm_pkg::out_item_t     out_item,
  output logic                     out_strobe
);

  localparam int CH_W = rgbmm_pkg::CH_W;

  rgbmm_pkg::rgb_t acc_r, acc_nxt, base;
  rgbmm_pkg::out_item_t out_item_r;
  logic out_strobe_r;
  logic [2*CH_W-1:0] prod_red, prod_green, prod_blue;
  logic [CH_W-1:0]   add_red, add_green, add_blue;

  assign prod_red   = left_q.red   * right_q.red;
  assign prod_green = left_q.green * right_q.green;
  assign prod_blue  = left_q.blue  * right_q.blue;

  // only the low byte of each product matters modulo 256
  always_comb begin
    base      = ctl.clear ? '0 : acc_r;
    add_red   = ctl.acc ? prod_red[CH_W-1:0]   : '0;
    add_green = ctl.acc ? prod_green[CH_W-1:0] : '0;
    add_blue  = ctl.acc ? prod_blue[CH_W-1:0]  : '0;
    acc_nxt.red   = CH_W'(base.red   + add_red);
    acc_nxt.green = CH_W'(base.green + add_green);
    acc_nxt.blue  = CH_W'(base.blue  + add_blue);
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (ctl.emit) begin
      out_item_r.red_out      <= acc_nxt.red;
      out_item_r.green_out    <= acc_nxt.green;
      out_item_r.blue_out     <= acc_nxt.blue;
      out_item_r.out_of_range <= ctl.oor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctl.emit;
    end
  end

  assign out_item   = out_item_r;
  assign out_strobe = out_strobe_r;

endmodule

`default_nettype wire

// File: sim/rgbmm_checker.sv
// ----------------------------------------------------------------------------
// rgbmm_checker
// Watches the item, result and register ports of the rgb matrix multiplier,
// keeps its own copy of both element stores and of the dimensions, works out
// each query's three channel dot products (mod 256) or its out-of-range flag,
// and compares every result strobe with the oldest outstanding query.
// ----------------------------------------------------------------------------
module rgbmm_checker #(
  parameter int MAX_DIM = rgbmm_pkg::MAX_DIM_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic                         busy,
  input  rgbmm_pkg::in_item_t               in_item,
  input  wire logic                         out_strobe,
  input  rgbmm_pkg::out_item_t              out_item,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rgbmm_pkg::CFG_AW-1:0] paddr,
  input  wire logic [rgbmm_pkg::CFG_DW-1:0] pwdata,
  input  wire logic                         pready,
  output int                                n_failures,
  output int                                n_waiting
);
  import rgbmm_pkg::*;

  rgb_t             left_mat  [MAX_DIM*MAX_DIM];
  rgb_t             right_mat [MAX_DIM*MAX_DIM];
  logic [DIM_W-1:0] rows_q;
  logic [DIM_W-1:0] inner_q;
  logic [DIM_W-1:0] cols_q;
  out_item_t        product_q [$];

  initial begin
    n_failures = 0;
    n_waiting  = 0;
  end

  // only the low five bits count, anything above MAX_DIM acts as MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_DW-1:0] v);
    logic [DIM_W-1:0] d;
    d = v[DIM_W-1:0];
    return (d > MAX_DIM) ? DIM_W'(MAX_DIM) : d;
  endfunction

  function automatic out_item_t product_at(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    out_item_t res;
    rgb_t      a;
    rgb_t      b;
    res = '0;
    if (r >= rows_q || c >= cols_q) begin
      res.out_of_range = 1'b1;
      return res;
    end
    // 8-bit sums wrap exactly as the byte-wide result does
    for (int j = 0; j < inner_q; j++) begin
      a = left_mat[r*MAX_DIM + j];
      b = right_mat[j*MAX_DIM + c];
      res.red_out   = res.red_out + a.red * b.red;
      res.green_out = res.green_out + a.green * b.green;
      res.blue_out  = res.blue_out + a.blue * b.blue;
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      n_failures++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      rows_q  <= DIM_W'(DIM_RESET);
      inner_q <= DIM_W'(DIM_RESET);
      cols_q  <= DIM_W'(DIM_RESET);
      product_q.delete();
      n_waiting <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (paddr[CFG_AW-1:2])
          REG_LEFT_ROWS:  rows_q  <= clamp_dim(pwdata);
          REG_INNER_SIZE: inner_q <= clamp_dim(pwdata);
          REG_RIGHT_COLS: cols_q  <= clamp_dim(pwdata);
          default: ;
        endcase
      end

      // results first: a strobe always belongs to an older query
      if (out_strobe) begin
        if (product_q.size() == 0) begin
          $error("result with no query outstanding: rgb %0h %0h %0h, out_of_range %0b",
                 out_item.red_out, out_item.green_out, out_item.blue_out,
                 out_item.out_of_range);
          n_failures++;
        end else begin
          want = product_q.pop_front();
          check_field("red_out", want.red_out, out_item.red_out);
          check_field("green_out", want.green_out, out_item.green_out);
          check_field("blue_out", want.blue_out, out_item.blue_out);
          check_field("out_of_range", CH_W'(want.out_of_range), CH_W'(out_item.out_of_range));
        end
      end

      if (start && !busy) begin
        case (in_item.kind)
          KIND_LEFT: begin
            if (in_item.row_index < rows_q && in_item.col_index < inner_q)
              left_mat[in_item.row_index*MAX_DIM + in_item.col_index] =
                {in_item.red_in, in_item.green_in, in_item.blue_in};
          end
          KIND_RIGHT: begin
            if (in_item.row_index < inner_q && in_item.col_index < cols_q)
              right_mat[in_item.row_index*MAX_DIM + in_item.col_index] =
                {in_item.red_in, in_item.green_in, in_item.blue_in};
          end
          KIND_QUERY: product_q.push_back(product_at(in_item.row_index, in_item.col_index));
          default: ;
        endcase
      end
      n_waiting <= product_q.size();
    end
  end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the rgb matrix multiplier: loads and queries under several
// dimension settings (zero, one, full and above the limit), with random
// sender gaps. Every in-range query first loads any element it would read
// that was never written. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_top;
  import rgbmm_pkg::*;

  localparam int MAX_DIM      = MAX_DIM_DEF;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = MAX_DIM + 4;
  localparam int N_ITEMS      = 1400;
  localparam int N_PHASES     = 12;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_item_t          in_item;
  logic              out_strobe;
  out_item_t         out_item;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int n_failures;
  int n_waiting;
  int cycle_count = 0;
  int idle_pct    = 35;
  int n_counted   = 0;

  // dimensions as the block sees them, and which store entries hold data
  logic [DIM_W-1:0] rows_now  = DIM_W'(DIM_RESET);
  logic [DIM_W-1:0] inner_now = DIM_W'(DIM_RESET);
  logic [DIM_W-1:0] cols_now  = DIM_W'(DIM_RESET);
  bit left_loaded  [MAX_DIM*MAX_DIM];
  bit right_loaded [MAX_DIM*MAX_DIM];

  rgb_channel_matrix_multiply #(.MAX_DIM(MAX_DIM)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rgbmm_checker #(.MAX_DIM(MAX_DIM)) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
    .n_failures(n_failures), .n_waiting(n_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // fill < 0 gives random channel bytes
  function automatic in_item_t make_item(logic [KIND_W-1:0] k, logic [IDX_W-1:0] r,
                                         logic [IDX_W-1:0] c, int fill = -1);
    in_item_t it;
    it.kind      = k;
    it.row_index = r;
    it.col_index = c;
    it.red_in    = (fill < 0) ? CH_W'($urandom) : CH_W'(fill);
    it.green_in  = (fill < 0) ? CH_W'($urandom) : CH_W'(fill);
    it.blue_in   = (fill < 0) ? CH_W'($urandom) : CH_W'(fill);
    return it;
  endfunction

  // mostly inside the current dimension, sometimes anywhere
  function automatic logic [IDX_W-1:0] near_index(logic [DIM_W-1:0] dim);
    if (dim == 0 || $urandom_range(9) == 0)
      return IDX_W'($urandom_range(MAX_DIM - 1));
    return IDX_W'($urandom_range(dim - 1));
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int p;
    p = $urandom_range(19);
    if (p == 0) return '0;
    if (p == 1) return DIM_W'($urandom_range(31, MAX_DIM));
    return DIM_W'($urandom_range(6, 1));
  endfunction

  task automatic send_item(in_item_t it);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (it.kind)
      KIND_LEFT: begin
        if (it.row_index < rows_now && it.col_index < inner_now)
          left_loaded[it.row_index*MAX_DIM + it.col_index] = 1'b1;
      end
      KIND_RIGHT: begin
        if (it.row_index < inner_now && it.col_index < cols_now)
          right_loaded[it.row_index*MAX_DIM + it.col_index] = 1'b1;
      end
      default: ;
    endcase
    n_counted++;
  endtask

  // loads whatever the query would read that was never written, then queries
  task automatic query_at(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    if (r < rows_now && c < cols_now) begin
      for (int j = 0; j < inner_now; j++) begin
        if (!left_loaded[r*MAX_DIM + j])
          send_item(make_item(KIND_LEFT, r, IDX_W'(j)));
        if (!right_loaded[j*MAX_DIM + c])
          send_item(make_item(KIND_RIGHT, IDX_W'(j), c));
      end
    end
    send_item(make_item(KIND_QUERY, r, c));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (n_waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    logic [DIM_W-1:0] eff;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // upper bits are don't-care to the block, so vary them now and then
    pwdata  <= ($urandom_range(3) == 0) ? {(CFG_DW-DIM_W)'($urandom), val} : CFG_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    eff = (val > MAX_DIM) ? DIM_W'(MAX_DIM) : val;
    case (idx)
      REG_LEFT_ROWS:  rows_now  = eff;
      REG_INNER_SIZE: inner_now = eff;
      REG_RIGHT_COLS: cols_now  = eff;
      default: ;
    endcase
  endtask

  task automatic set_dims(logic [DIM_W-1:0] r, logic [DIM_W-1:0] i, logic [DIM_W-1:0] c);
    write_reg(REG_LEFT_ROWS, r);
    write_reg(REG_INNER_SIZE, i);
    write_reg(REG_RIGHT_COLS, c);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35)
      send_item(make_item(KIND_LEFT, near_index(rows_now), near_index(inner_now)));
    else if (pick < 70)
      send_item(make_item(KIND_RIGHT, near_index(inner_now), near_index(cols_now)));
    else if (pick < 95)
      query_at(near_index(rows_now), near_index(cols_now));
    else
      send_item(make_item(KIND_UNUSED, IDX_W'($urandom), IDX_W'($urandom)));
  endtask

  initial begin
    int target;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: unused kind, one by one products, ignored loads, empty dims
    send_item(make_item(KIND_UNUSED, '1, '1, 255));
    set_dims(1, 1, 1);
    send_item(make_item(KIND_LEFT, 0, 0, 255));
    send_item(make_item(KIND_RIGHT, 0, 0, 255));
    query_at(0, 0);
    send_item(make_item(KIND_LEFT, 0, 1, 0));
    send_item(make_item(KIND_LEFT, 1, 0, 0));
    send_item(make_item(KIND_RIGHT, 1, 0, 0));
    send_item(make_item(KIND_RIGHT, 0, 1, 0));
    query_at(0, 0);
    query_at(15, 15);
    query_at(0, 15);
    query_at(15, 0);
    send_item(make_item(KIND_LEFT, 0, 0, 0));
    query_at(0, 0);
    set_dims(1, 0, 1);
    send_item(make_item(KIND_LEFT, 0, 0, 255));
    query_at(0, 0);
    set_dims(0, 1, 1);
    query_at(0, 0);
    set_dims(31, 1, 31);
    query_at(15, 15);

    // random: sender gaps at 35 then 57 percent, then back to back
    for (int ph = 0; ph < N_PHASES; ph++) begin
      idle_pct = (ph < N_PHASES/3) ? 35 : (ph < 2*N_PHASES/3) ? 57 : 0;
      case (ph)
        0:       set_dims(16, 16, 16);
        1:       set_dims(1, 1, 1);
        2:       set_dims(31, 31, 31);
        default: set_dims(pick_dim(), pick_dim(), pick_dim());
      endcase
      target = n_counted + N_ITEMS / N_PHASES;
      while (n_counted < target) random_item();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
